@@ sv/cbd_pkg.sv @@
// Shared types, constants and address map of the console bus decoder.
package cbd_pkg;

    localparam int RAM_BYTES       = 2048;
    localparam int RAM_AW          = $clog2(RAM_BYTES);
    localparam int TICKS_PER_FRAME = 29781 * 3;
    localparam int FRAME_W         = 17;

    localparam logic [15:0] ADDR_RAM_TOP  = 16'h1FFF;
    localparam logic [15:0] ADDR_PPU_TOP  = 16'h3FFF;
    localparam logic [15:0] ADDR_IO_TOP   = 16'h401F;
    localparam logic [15:0] ADDR_OAM_DMA  = 16'h4014;
    localparam logic [15:0] ADDR_JOYPAD   = 16'h4016;
    localparam logic [2:0]  STROBE_MASK   = 3'h7;
    localparam logic [2:0]  STROBE_REQ    = 3'h1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ROUTE_INSIDE = 2'd0,
        ROUTE_PPU    = 2'd1,
        ROUTE_CART   = 2'd2,
        ROUTE_IDLE   = 2'd3
    } t_route;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  buttons;
        logic        ppu_nmi;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        t_route     route;
        logic [2:0] ppu_register;
        logic       dma_start;
        logic [7:0] dma_page;
        logic       cpu_step;
        logic       nmi_to_cpu;
        logic       frame_done;
    } t_result;

endpackage

@@ sv/console_bus_decoder_core.sv @@
// Top level of the console bus decoder: item pipeline, work RAM and result register.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one item per cycle:
//   a PPU-rate tick, a CPU bus read or a CPU bus write. The output channel
//   (o_out_valid / i_out_ready) returns exactly one result item per input
//   item, in order.
//   Order: an accepted item enters the input register together with its
//   work RAM read data, is decoded and placed in the result register when
//   the input stage advances, which raises o_out_valid.
//   Throughput: one item per cycle while the receiver takes results; the
//   input register and the result register each hold one item, so a new
//   item is taken while a finished result still waits.
//   Receiver stall: the result register holds; the input register then
//   holds too and o_in_ready drops until the receiver takes the result.
//   Reset: control state clears, and a clearing pass writes zero to every
//   work RAM byte, one per cycle, RAM_BYTES (2048) bytes in all; o_in_ready
//   stays low throughout the pass.
module console_bus_decoder_core
    import cbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_buttons,
    input  logic        i_ppu_nmi,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_route,
    output logic [2:0]  o_ppu_register,
    output logic        o_dma_start,
    output logic [7:0]  o_dma_page,
    output logic        o_cpu_step,
    output logic        o_nmi_to_cpu,
    output logic        o_frame_done
);

    // Clearing pass over the work RAM after reset
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_idx;

    // Input register stage
    logic  r_s1_valid;
    t_item r_s1;

    // Result register stage
    logic    r_out_valid;
    t_result r_out;

    logic              accept;
    logic              s1_adv;
    logic              in_ram;
    logic [RAM_AW-1:0] ram_idx;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    t_result           result;

    // Advance the input stage whenever the result register is free or emptying
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept     = i_in_valid && o_in_ready;

    // Work RAM mirrors through 0x0000-0x1FFF
    assign in_ram  = (i_address <= ADDR_RAM_TOP);
    assign ram_idx = RAM_AW'({1'b0, i_address[12:0]} % 14'(RAM_BYTES));

    // Writes land at acceptance, so a following read sees them
    assign ram_we    = r_clr_busy
                    || (accept && (t_cmd'(i_command) == CMD_WRITE) && in_ram);
    assign ram_waddr = r_clr_busy ? r_clr_idx : ram_idx;
    assign ram_wdata = r_clr_busy ? 8'd0 : i_write_data;

    cbd_work_ram #(
        .DEPTH (RAM_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ram_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= RAM_AW'(r_clr_idx + 1'b1);
            if (r_clr_idx == RAM_AW'(RAM_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Input register: valid tracks acceptance against advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.cmd        <= t_cmd'(i_command);
            r_s1.address    <= i_address;
            r_s1.write_data <= i_write_data;
            r_s1.buttons    <= i_buttons;
            r_s1.ppu_nmi    <= i_ppu_nmi;
        end
    end

    cbd_io_state u_io (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (r_s1),
        .i_ram_data (ram_rdata),
        .i_fire     (s1_adv),
        .o_result   (result)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out.read_data;
    assign o_route        = r_out.route;
    assign o_ppu_register = r_out.ppu_register;
    assign o_dma_start    = r_out.dma_start;
    assign o_dma_page     = r_out.dma_page;
    assign o_cpu_step     = r_out.cpu_step;
    assign o_nmi_to_cpu   = r_out.nmi_to_cpu;
    assign o_frame_done   = r_out.frame_done;

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept)
        else $error("item accepted during work RAM clearing pass");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are blocked");

    a_dma_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.dma_start) |-> (r_out.route == ROUTE_INSIDE))
        else $error("DMA start on a result not handled inside");

endmodule

@@ sv/cbd_work_ram.sv @@
// Single-port-write, registered-read RAM holding the CPU work memory.
module cbd_work_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cbd_io_state.sv @@
// Address decode, controller port, CPU divider and frame counter.
module cbd_io_state
    import cbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic [7:0] i_ram_data,
    input  logic       i_fire,
    output t_result    o_result
);

    logic [7:0]         r_shift;
    logic               r_armed;
    logic [1:0]         r_phase;
    logic [FRAME_W-1:0] r_frame;

    logic [7:0]         n_shift;
    logic               n_armed;
    logic [1:0]         n_phase;
    logic [FRAME_W-1:0] n_frame;

    t_result res;
    logic    is_write;
    logic    req;

    always_comb begin
        res          = '0;
        res.route    = ROUTE_IDLE;
        n_shift      = r_shift;
        n_armed      = r_armed;
        n_phase      = r_phase;
        n_frame      = r_frame;
        is_write     = (i_item.cmd == CMD_WRITE);
        req          = ((i_item.write_data[2:0] & STROBE_MASK) == STROBE_REQ);
        unique case (i_item.cmd) inside
            CMD_TICK: begin
                res.cpu_step   = (r_phase == 2'd0);
                res.nmi_to_cpu = i_item.ppu_nmi;
                res.frame_done = (r_frame == '0);
                n_phase = (r_phase == 2'd2) ? 2'd0 : 2'(r_phase + 2'd1);
                n_frame = (r_frame == FRAME_W'(TICKS_PER_FRAME - 1)) ? '0
                        : FRAME_W'(r_frame + 1'b1);
            end
            CMD_READ, CMD_WRITE: begin
                if (i_item.address <= ADDR_RAM_TOP) begin
                    res.route = ROUTE_INSIDE;
                    if (!is_write) begin
                        res.read_data = i_ram_data;
                    end
                end else if (i_item.address <= ADDR_PPU_TOP) begin
                    res.route        = ROUTE_PPU;
                    res.ppu_register = i_item.address[2:0];
                end else if (i_item.address <= ADDR_IO_TOP) begin
                    res.route = ROUTE_INSIDE;
                    if (is_write) begin
                        if (i_item.address == ADDR_OAM_DMA) begin
                            res.dma_start = 1'b1;
                            res.dma_page  = i_item.write_data;
                        end else if (i_item.address == ADDR_JOYPAD) begin
                            // latch on the falling strobe, then disarm
                            if (r_armed && !req) begin
                                n_shift = i_item.buttons;
                                n_armed = 1'b0;
                            end else if (!r_armed && req) begin
                                n_armed = 1'b1;
                            end
                        end
                    end else if (i_item.address == ADDR_JOYPAD) begin
                        res.read_data = {7'd0, r_shift[0]};
                        n_shift       = {1'b0, r_shift[7:1]};
                    end
                end else begin
                    res.route = ROUTE_CART;
                end
            end
            default: begin
                res.route = ROUTE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_armed <= 1'b0;
            r_phase <= '0;
            r_frame <= '0;
        end else if (i_fire) begin
            r_shift <= n_shift;
            r_armed <= n_armed;
            r_phase <= n_phase;
            r_frame <= n_frame;
        end
    end

    assign o_result = res;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("cpu phase left its 0..2 range");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame < FRAME_W'(TICKS_PER_FRAME))
        else $error("frame counter beyond frame length");

endmodule
